@@ rtl/btib_pkg.sv @@
// Package for the box track id binder: sizes, codes and shared types.
// Used by btib_ovl and box_track_id_binder_core; depends on nothing.
package btib_pkg;

  localparam int POOLS      = 8;
  localparam int MAX_DETECT = 16;
  localparam int COORD_BITS = 12;

  localparam int PIDX_W = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int PCNT_W = $clog2(POOLS + 1);
  localparam int DIDX_W = (MAX_DETECT > 1) ? $clog2(MAX_DETECT) : 1;
  localparam int DCNT_W = $clog2(MAX_DETECT + 1);
  localparam int AREA_W = 2 * COORD_BITS;
  localparam int PROD_W = AREA_W + 8;
  localparam int NREP   = (POOLS < 8) ? POOLS : 8;

  localparam int ID_W   = 16;
  localparam int OUT_W  = 72;
  localparam int IN_W   = 64;
  localparam int BOX_W  = 12;
  localparam int OIDX_W = 3;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_MATCH  = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_LOOKUP = 2'd3;

  localparam logic [1:0] CFG_MUST   = 2'd0;
  localparam logic [1:0] CFG_MIN    = 2'd1;
  localparam logic [1:0] CFG_FILTER = 2'd2;
  localparam logic [1:0] CFG_HOLD   = 2'd3;

  localparam logic [1:0] TAG_OWNED   = 2'd0;
  localparam logic [1:0] TAG_UNOWNED = 2'd1;
  localparam logic [1:0] TAG_CLEARED = 2'd3;

  localparam logic [1:0] STAT_OWNED   = 2'd0;
  localparam logic [1:0] STAT_UNOWNED = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_CLEARED = 2'd3;

  localparam logic [7:0] MUST_RESET   = 8'd128;
  localparam logic [7:0] MIN_RESET    = 8'd64;
  localparam logic [7:0] FILTER_RESET = 8'd32;
  localparam logic [7:0] HOLD_RESET   = 8'd10;

  typedef struct packed {
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
  } box_t;

  typedef struct packed {
    box_t            box;
    logic [ID_W-1:0] id;
  } det_t;

  typedef struct packed {
    logic pass;
    logic smaller;
  } ovl_res_t;

  function automatic logic [COORD_BITS-1:0] span(input logic [COORD_BITS-1:0] lo,
                                                 input logic [COORD_BITS-1:0] hi);
    return (hi > lo) ? (hi - lo) : '0;
  endfunction

endpackage

@@ rtl/btib_ovl.sv @@
// Three-stage overlap test of one pool box against one detection box.
// Depends on btib_pkg; the spans, the areas and the scaled products are registered in turn.
module btib_ovl (
  input  logic                     clk,
  input  btib_pkg::box_t           pool,
  input  btib_pkg::box_t           det,
  input  logic [7:0]               must_ratio,
  input  logic [7:0]               min_ratio,
  input  logic [7:0]               filter_ratio,
  output btib_pkg::ovl_res_t       res
);

  logic [btib_pkg::COORD_BITS-1:0] pw, ph, dw, dh, iw, ih;
  logic [btib_pkg::AREA_W-1:0]     pa, da, ia;
  logic [btib_pkg::PROD_W-1:0]     ia8, must_pa, min_da, must_da, filter_pa;
  logic                            smaller;
  logic [btib_pkg::COORD_BITS-1:0] lx, ly, rx, ry;

  always_comb begin
    lx = (pool.x0 > det.x0) ? pool.x0 : det.x0;
    ly = (pool.y0 > det.y0) ? pool.y0 : det.y0;
    rx = (pool.x1 < det.x1) ? pool.x1 : det.x1;
    ry = (pool.y1 < det.y1) ? pool.y1 : det.y1;
  end

  always_ff @(posedge clk) begin
    pw <= btib_pkg::span(pool.x0, pool.x1);
    ph <= btib_pkg::span(pool.y0, pool.y1);
    dw <= btib_pkg::span(det.x0, det.x1);
    dh <= btib_pkg::span(det.y0, det.y1);
    iw <= btib_pkg::span(lx, rx);
    ih <= btib_pkg::span(ly, ry);

    pa <= btib_pkg::AREA_W'(pw * ph);
    da <= btib_pkg::AREA_W'(dw * dh);
    ia <= btib_pkg::AREA_W'(iw * ih);

    ia8       <= {ia, 8'd0};
    must_pa   <= btib_pkg::PROD_W'(must_ratio * pa);
    min_da    <= btib_pkg::PROD_W'(min_ratio * da);
    must_da   <= btib_pkg::PROD_W'(must_ratio * da);
    filter_pa <= btib_pkg::PROD_W'(filter_ratio * pa);
    smaller   <= (pa < da);
  end

  assign res.pass    = ((ia8 > must_pa) && (ia8 > min_da)) ||
                       ((ia8 > must_da) && (ia8 > filter_pa));
  assign res.smaller = smaller;

endmodule

@@ rtl/box_track_id_binder_core.sv @@
// Top level of the box track id binder: handshakes, pool state, detection buffer, sequencer.
// Depends on btib_pkg and btib_ovl.
//
// An add or a tick item is handled in the idle state and gives no result. A lookup loads its
// one result into the output register from the S_LOOKUP state once that register is free. A
// match item has a setup state, then for each buffered detection a read state and, for each
// pool tested until one passes, the four steps S_P1 to S_P4 of the overlap test; a last read
// state ends the search. Empty pools are then filled from the detection buffer; each report
// item is loaded as soon as the output register is free. A new item is taken once the previous
// one has finished; the output register holds a result until taken.
module box_track_id_binder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // up_x, up_y, down_x, down_y, detection id
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // slot, status, found, box_left, box_top,
                                 // box_right, box_bottom, owner_id, zero pad
  output logic        m_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MINIT, S_DRD, S_P1, S_P2, S_P3, S_P4, S_FILL, S_FBIND, S_REPORT, S_LOOKUP
  } state_t;

  state_t state;

  logic [7:0] must_ratio, min_ratio, filter_ratio, hold_frames;

  btib_pkg::box_t                  pool_box   [btib_pkg::POOLS];
  logic [btib_pkg::ID_W-1:0]       pool_owner [btib_pkg::POOLS];
  logic [1:0]                      pool_tag   [btib_pkg::POOLS];
  logic                            pool_empty [btib_pkg::POOLS];
  logic [7:0]                      pool_hold  [btib_pkg::POOLS];

  btib_pkg::det_t                  pend_mem [btib_pkg::MAX_DETECT];
  btib_pkg::det_t                  rd_data;
  logic                            rd_en;
  logic [btib_pkg::DCNT_W-1:0]     pend_cnt;
  logic [btib_pkg::MAX_DETECT-1:0] placed;

  logic [btib_pkg::PCNT_W-1:0]     pcnt;
  logic [btib_pkg::DCNT_W-1:0]     dcnt;
  logic [btib_pkg::PIDX_W-1:0]     pi;
  logic [btib_pkg::DIDX_W-1:0]     di;
  logic [btib_pkg::ID_W-1:0]       lk_id;

  logic                            out_valid;
  logic [btib_pkg::OUT_W-1:0]      out_data;
  logic                            out_last;
  logic                            out_free;
  logic                            out_load;

  btib_pkg::det_t                  in_det;
  btib_pkg::ovl_res_t              ovl;
  logic                            lk_hit;
  logic [btib_pkg::PIDX_W-1:0]     lk_idx;
  logic [1:0]                      rep_stat;

  assign pi        = pcnt[btib_pkg::PIDX_W-1:0];
  assign di        = dcnt[btib_pkg::DIDX_W-1:0];
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;
  assign m_tlast   = out_last;
  assign out_free  = !out_valid || m_tready;
  assign out_load  = out_free && ((state == S_REPORT) || (state == S_LOOKUP));

  assign in_det.box.x0 = s_tdata[11:0];
  assign in_det.box.y0 = s_tdata[23:12];
  assign in_det.box.x1 = s_tdata[35:24];
  assign in_det.box.y1 = s_tdata[47:36];
  assign in_det.id     = s_tdata[63:48];

  assign rd_en = (state == S_DRD) ||
                 ((state == S_FILL) && (pcnt != btib_pkg::PCNT_W'(btib_pkg::POOLS)) &&
                  pool_empty[pi] && (dcnt < pend_cnt) && !placed[di]);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && (s_tuser == btib_pkg::CMD_ADD) &&
        (pend_cnt < btib_pkg::DCNT_W'(btib_pkg::MAX_DETECT))) begin
      pend_mem[pend_cnt[btib_pkg::DIDX_W-1:0]] <= in_det;
    end
    if (rd_en) begin
      rd_data <= pend_mem[di];
    end
  end

  btib_ovl u_ovl (
    .clk          (clk),
    .pool         (pool_box[pi]),
    .det          (rd_data.box),
    .must_ratio   (must_ratio),
    .min_ratio    (min_ratio),
    .filter_ratio (filter_ratio),
    .res          (ovl)
  );

  always_comb begin
    lk_hit = 1'b0;
    lk_idx = '0;
    for (int i = btib_pkg::POOLS - 1; i >= 0; i--) begin
      if (!pool_empty[i] && (pool_tag[i] == btib_pkg::TAG_OWNED) &&
          (pool_owner[i] == lk_id)) begin
        lk_hit = 1'b1;
        lk_idx = btib_pkg::PIDX_W'(i);
      end
    end
  end

  always_comb begin
    if (pool_tag[pi] == btib_pkg::TAG_CLEARED) begin
      rep_stat = btib_pkg::STAT_CLEARED;
    end else if (pool_empty[pi]) begin
      rep_stat = btib_pkg::STAT_EMPTY;
    end else if (pool_tag[pi] == btib_pkg::TAG_UNOWNED) begin
      rep_stat = btib_pkg::STAT_UNOWNED;
    end else begin
      rep_stat = btib_pkg::STAT_OWNED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      must_ratio   <= btib_pkg::MUST_RESET;
      min_ratio    <= btib_pkg::MIN_RESET;
      filter_ratio <= btib_pkg::FILTER_RESET;
      hold_frames  <= btib_pkg::HOLD_RESET;
      pend_cnt     <= '0;
      placed       <= '0;
      pcnt         <= '0;
      dcnt         <= '0;
      out_valid    <= 1'b0;
      out_last     <= 1'b0;
      out_data     <= '0;
      lk_id        <= '0;
      for (int i = 0; i < btib_pkg::POOLS; i++) begin
        pool_box[i]   <= '0;
        pool_owner[i] <= '0;
        pool_tag[i]   <= btib_pkg::TAG_UNOWNED;
        pool_empty[i] <= 1'b1;
        pool_hold[i]  <= btib_pkg::HOLD_RESET;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          btib_pkg::CFG_MUST:   must_ratio   <= cfg_data;
          btib_pkg::CFG_MIN:    min_ratio    <= cfg_data;
          btib_pkg::CFG_FILTER: filter_ratio <= cfg_data;
          btib_pkg::CFG_HOLD:   hold_frames  <= cfg_data;
          default: ;
        endcase
      end
      if (m_tready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            unique case (s_tuser)
              btib_pkg::CMD_ADD: begin
                if (pend_cnt < btib_pkg::DCNT_W'(btib_pkg::MAX_DETECT)) begin
                  pend_cnt <= pend_cnt + 1'b1;
                end
              end
              btib_pkg::CMD_MATCH: state <= S_MINIT;
              btib_pkg::CMD_TICK: begin
                for (int i = 0; i < btib_pkg::POOLS; i++) begin
                  if (pool_tag[i] == btib_pkg::TAG_UNOWNED) begin
                    pool_hold[i] <= (pool_hold[i] > 8'd1) ? pool_hold[i] - 8'd1 : 8'd0;
                    if (pool_hold[i] <= 8'd1) begin
                      pool_tag[i]   <= btib_pkg::TAG_CLEARED;
                      pool_box[i]   <= '0;
                      pool_empty[i] <= 1'b1;
                    end
                  end
                end
              end
              btib_pkg::CMD_LOOKUP: begin
                lk_id <= in_det.id;
                state <= S_LOOKUP;
              end
              default: ;
            endcase
          end
        end
        S_MINIT: begin
          for (int i = 0; i < btib_pkg::POOLS; i++) begin
            pool_tag[i] <= btib_pkg::TAG_UNOWNED;
          end
          placed <= '0;
          dcnt   <= '0;
          state  <= S_DRD;
        end
        S_DRD: begin
          pcnt <= '0;
          if (dcnt == pend_cnt) begin
            dcnt  <= '0;
            state <= S_FILL;
          end else begin
            state <= S_P1;
          end
        end
        S_P1: state <= S_P2;
        S_P2: state <= S_P3;
        S_P3: state <= S_P4;
        S_P4: begin
          if (!pool_empty[pi] && ovl.pass) begin
            if ((pool_tag[pi] != btib_pkg::TAG_OWNED) || ovl.smaller) begin
              pool_box[pi]   <= rd_data.box;
              pool_owner[pi] <= rd_data.id;
              pool_tag[pi]   <= btib_pkg::TAG_OWNED;
            end
            pool_hold[pi] <= hold_frames;
            placed[di]    <= 1'b1;
            dcnt          <= dcnt + 1'b1;
            state         <= S_DRD;
          end else if (pcnt == btib_pkg::PCNT_W'(btib_pkg::POOLS - 1)) begin
            dcnt  <= dcnt + 1'b1;
            state <= S_DRD;
          end else begin
            pcnt  <= pcnt + 1'b1;
            state <= S_P1;
          end
        end
        S_FILL: begin
          priority if (pcnt == btib_pkg::PCNT_W'(btib_pkg::POOLS) || (pool_empty[pi] &&
                       dcnt >= pend_cnt)) begin
            pcnt     <= '0;
            pend_cnt <= '0;
            state    <= S_REPORT;
          end else if (!pool_empty[pi]) begin
            pcnt <= pcnt + 1'b1;
          end else if (placed[di]) begin
            dcnt <= dcnt + 1'b1;
          end else begin
            state <= S_FBIND;
          end
        end
        S_FBIND: begin
          pool_box[pi]   <= rd_data.box;
          pool_owner[pi] <= rd_data.id;
          pool_tag[pi]   <= btib_pkg::TAG_OWNED;
          pool_hold[pi]  <= hold_frames;
          pool_empty[pi] <= 1'b0;
          placed[di]     <= 1'b1;
          pcnt           <= pcnt + 1'b1;
          state          <= S_FILL;
        end
        S_REPORT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_last  <= (pcnt == btib_pkg::PCNT_W'(btib_pkg::NREP - 1));
            if (rep_stat == btib_pkg::STAT_OWNED) begin
              out_data <= {2'b00, pool_owner[pi],
                           btib_pkg::BOX_W'(pool_box[pi].y1), btib_pkg::BOX_W'(pool_box[pi].x1),
                           btib_pkg::BOX_W'(pool_box[pi].y0), btib_pkg::BOX_W'(pool_box[pi].x0),
                           1'b0, rep_stat, btib_pkg::OIDX_W'(pcnt)};
            end else begin
              out_data <= {67'd0, rep_stat, btib_pkg::OIDX_W'(pcnt)};
            end
            if (pcnt == btib_pkg::PCNT_W'(btib_pkg::NREP - 1)) begin
              state <= S_IDLE;
            end else begin
              pcnt <= pcnt + 1'b1;
            end
          end
        end
        S_LOOKUP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_last  <= 1'b1;
            if (lk_hit) begin
              out_data <= {2'b00, pool_owner[lk_idx],
                           btib_pkg::BOX_W'(pool_box[lk_idx].y1),
                           btib_pkg::BOX_W'(pool_box[lk_idx].x1),
                           btib_pkg::BOX_W'(pool_box[lk_idx].y0),
                           btib_pkg::BOX_W'(pool_box[lk_idx].x0),
                           1'b1, btib_pkg::STAT_OWNED, btib_pkg::OIDX_W'(lk_idx)};
            end else begin
              out_data <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend_cnt <= btib_pkg::DCNT_W'(btib_pkg::MAX_DETECT))
    else $error("detection count beyond buffer depth");

  a_fill_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_FBIND |-> pool_empty[pi] && !placed[di])
    else $error("fill binds a busy pool or a placed detection");

  a_found_owned: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> m_tdata[4:3] == btib_pkg::STAT_OWNED && m_tlast)
    else $error("lookup hit without owned status");

  a_report_end: assert property (@(posedge clk) disable iff (rst)
    state == S_REPORT && out_free && pcnt == btib_pkg::PCNT_W'(btib_pkg::NREP - 1)
    |=> state == S_IDLE && m_tlast && pend_cnt == '0)
    else $error("report did not close the frame");

endmodule

@@ verif/tb_box_track_id_binder_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for box_track_id_binder_core: frames of detections, matches, ticks
// and lookups are predicted in the bench and compared with each report item.
// Depends on btib_pkg and the RTL of the block.
module tb_box_track_id_binder_core;

  localparam int LIMIT = 1500000;

  typedef struct {
    logic [2:0]     pidx;
    logic [1:0]     stat;
    logic           fnd;
    btib_pkg::box_t b;
    logic [15:0]    owner;
    logic           last;
  } report_t;

  typedef struct {
    logic [1:0]     cmd;
    btib_pkg::box_t b;
    logic [15:0]    id;
  } cmd_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = btib_pkg::CMD_ADD;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = btib_pkg::CFG_MUST;
  logic [7:0]  cfg_data = '0;

  box_track_id_binder_core dut (.*);

  cmd_item_t pending_items[$];
  report_t   expected_reports[$];
  int        fails = 0;
  int        cycles = 0;

  logic [7:0]     th_must, th_min, th_filter, th_hold;
  btib_pkg::box_t pool_b[btib_pkg::POOLS];
  logic [15:0]    pool_own[btib_pkg::POOLS];
  logic [1:0]     pool_tg[btib_pkg::POOLS];
  bit             pool_emp[btib_pkg::POOLS];
  logic [7:0]     pool_hld[btib_pkg::POOLS];
  btib_pkg::box_t det_b[btib_pkg::MAX_DETECT];
  logic [15:0]    det_id[btib_pkg::MAX_DETECT];
  int             det_n;

  btib_pkg::box_t track_base[10];
  logic [15:0]    id_pool[10];

  initial forever #10 clk = ~clk;

  function automatic longint extent(logic [11:0] lo, logic [11:0] hi);
    return (hi > lo) ? longint'(hi - lo) : 0;
  endfunction

  function automatic longint area_of(btib_pkg::box_t b);
    return extent(b.x0, b.x1) * extent(b.y0, b.y1);
  endfunction

  function automatic longint common_area(btib_pkg::box_t a, btib_pkg::box_t b);
    logic [11:0] lx, ly, rx, ry;
    lx = (a.x0 > b.x0) ? a.x0 : b.x0;
    ly = (a.y0 > b.y0) ? a.y0 : b.y0;
    rx = (a.x1 < b.x1) ? a.x1 : b.x1;
    ry = (a.y1 < b.y1) ? a.y1 : b.y1;
    return extent(lx, rx) * extent(ly, ry);
  endfunction

  function automatic bit over(longint i, longint a, logic [7:0] t);
    return i * 256 > longint'(t) * a;
  endfunction

  task automatic push_report(int p, logic [1:0] st, logic f, logic lst);
    report_t r;
    r.pidx = p[2:0];
    r.stat = st;
    r.fnd = f;
    r.b = (st == btib_pkg::STAT_OWNED) ? pool_b[p] : '0;
    r.owner = (st == btib_pkg::STAT_OWNED) ? pool_own[p] : '0;
    r.last = lst;
    expected_reports.insert(expected_reports.size(), r);
  endtask

  task automatic bind_track(int p, int d);
    pool_b[p] = det_b[d];
    pool_own[p] = det_id[d];
    pool_tg[p] = btib_pkg::TAG_OWNED;
  endtask

  task automatic reset_model();
    th_must = btib_pkg::MUST_RESET;
    th_min = btib_pkg::MIN_RESET;
    th_filter = btib_pkg::FILTER_RESET;
    th_hold = btib_pkg::HOLD_RESET;
    for (int p = 0; p < btib_pkg::POOLS; p++) begin
      pool_b[p] = '0; pool_own[p] = '0; pool_tg[p] = btib_pkg::TAG_UNOWNED;
      pool_emp[p] = 1; pool_hld[p] = btib_pkg::HOLD_RESET;
    end
    det_n = 0;
  endtask

  task automatic bind_frame();
    bit placed[btib_pkg::MAX_DETECT];
    longint da, pa, in;
    int d;
    for (int p = 0; p < btib_pkg::POOLS; p++) pool_tg[p] = btib_pkg::TAG_UNOWNED;
    for (d = 0; d < det_n; d++) begin
      da = area_of(det_b[d]);
      placed[d] = 0;
      for (int p = 0; p < btib_pkg::POOLS && da != 0; p++) begin
        if (pool_emp[p]) continue;
        pa = area_of(pool_b[p]);
        if (pa == 0) continue;
        in = common_area(pool_b[p], det_b[d]);
        if (!((over(in, pa, th_must) && over(in, da, th_min)) ||
              (over(in, da, th_must) && over(in, pa, th_filter)))) continue;
        if (pool_tg[p] != btib_pkg::TAG_OWNED || pa < da) bind_track(p, d);
        pool_hld[p] = th_hold;
        pool_emp[p] = 0;
        placed[d] = 1;
        break;
      end
    end
    d = 0;
    for (int p = 0; p < btib_pkg::POOLS; p++) begin
      if (!pool_emp[p]) continue;
      while (d < det_n && placed[d]) d++;
      if (d >= det_n) break;
      bind_track(p, d);
      pool_hld[p] = th_hold;
      pool_emp[p] = 0;
      placed[d] = 1;
    end
    det_n = 0;
  endtask

  task automatic predict_item(logic [1:0] cmd, logic [63:0] data);
    logic [1:0] st;
    bit hit;
    hit = 0;
    case (cmd)
      btib_pkg::CMD_ADD: begin
        if (det_n < btib_pkg::MAX_DETECT) begin
          det_b[det_n] = '{x0: data[11:0], y0: data[23:12], x1: data[35:24], y1: data[47:36]};
          det_id[det_n] = data[63:48];
          det_n++;
        end
      end
      btib_pkg::CMD_MATCH: begin
        bind_frame();
        for (int p = 0; p < btib_pkg::NREP; p++) begin
          if (pool_tg[p] == btib_pkg::TAG_CLEARED) st = btib_pkg::STAT_CLEARED;
          else if (pool_emp[p]) st = btib_pkg::STAT_EMPTY;
          else if (pool_tg[p] == btib_pkg::TAG_UNOWNED) st = btib_pkg::STAT_UNOWNED;
          else st = btib_pkg::STAT_OWNED;
          push_report(p, st, 1'b0, p == btib_pkg::NREP - 1);
        end
      end
      btib_pkg::CMD_TICK: begin
        for (int p = 0; p < btib_pkg::POOLS; p++) begin
          if (pool_tg[p] != btib_pkg::TAG_UNOWNED) continue;
          if (pool_hld[p] > 0) pool_hld[p]--;
          if (pool_hld[p] == 0) begin
            pool_tg[p] = btib_pkg::TAG_CLEARED; pool_b[p] = '0; pool_emp[p] = 1;
          end
        end
      end
      default: begin
        for (int p = 0; p < btib_pkg::POOLS && !hit; p++) begin
          if (!pool_emp[p] && pool_tg[p] == btib_pkg::TAG_OWNED &&
              pool_own[p] == data[63:48]) begin
            push_report(p, btib_pkg::STAT_OWNED, 1'b1, 1'b1);
            hit = 1;
          end
        end
        if (!hit) expected_reports.insert(expected_reports.size(), '{default: '0, last: 1'b1});
      end
    endcase
  endtask

  task automatic report_mismatch(string field, longint exp_v, longint got_v);
    $display("mismatch in %s: expected %0h, got %0h", field, exp_v, got_v);
    fails++;
  endtask

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        btib_pkg::CFG_MUST:   th_must = cfg_data;
        btib_pkg::CFG_MIN:    th_min = cfg_data;
        btib_pkg::CFG_FILTER: th_filter = cfg_data;
        default:              th_hold = cfg_data;
      endcase
    end
  end

  always @(posedge clk) begin
    report_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected item", 0, longint'(m_tdata[63:0]));
      end else begin
        e = expected_reports.pop_front();
        if (m_tdata[2:0] !== e.pidx) report_mismatch("slot", e.pidx, m_tdata[2:0]);
        if (m_tdata[4:3] !== e.stat) report_mismatch("status", e.stat, m_tdata[4:3]);
        if (m_tdata[5] !== e.fnd) report_mismatch("found", e.fnd, m_tdata[5]);
        if (m_tdata[17:6] !== e.b.x0) report_mismatch("box_left", e.b.x0, m_tdata[17:6]);
        if (m_tdata[29:18] !== e.b.y0) report_mismatch("box_top", e.b.y0, m_tdata[29:18]);
        if (m_tdata[41:30] !== e.b.x1) report_mismatch("box_right", e.b.x1, m_tdata[41:30]);
        if (m_tdata[53:42] !== e.b.y1) report_mismatch("box_bottom", e.b.y1, m_tdata[53:42]);
        if (m_tdata[69:54] !== e.owner) report_mismatch("owner_id", e.owner, m_tdata[69:54]);
        if (m_tdata[71:70] !== 2'b00) report_mismatch("pad", 0, m_tdata[71:70]);
        if (m_tlast !== e.last) report_mismatch("last", e.last, m_tlast);
      end
    end
  end

  // The sender drives bursts of random length separated by random gaps.
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    cmd_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        s_tdata <= {it.id, it.b.y1, it.b.x1, it.b.y0, it.b.x0};
        s_tuser <= it.cmd;
        s_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(12);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // The receiver switches at random among four stall patterns.
  int stall_mode = 0;
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(1));
      2: m_tready <= ($urandom_range(7) == 0);
      default: m_tready <= ((cycles % 8) < 5);
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_box_track_id_binder_core: FAIL");
      $finish;
    end
  end

  task automatic add_item(logic [1:0] cmd, btib_pkg::box_t b, logic [15:0] id);
    pending_items.insert(pending_items.size(), '{cmd: cmd, b: b, id: id});
  endtask

  function automatic btib_pkg::box_t random_box();
    btib_pkg::box_t b;
    b.x0 = 12'($urandom); b.y0 = 12'($urandom); b.x1 = 12'($urandom); b.y1 = 12'($urandom);
    return b;
  endfunction

  function automatic logic [11:0] jitter(logic [11:0] v);
    int r;
    r = int'(v) + int'($urandom_range(40)) - 20;
    return (r < 0) ? 12'd0 : (r > 4095) ? 12'd4095 : r[11:0];
  endfunction

  function automatic btib_pkg::box_t track_box();
    btib_pkg::box_t b;
    int k;
    k = $urandom_range(9);
    b = track_base[k];
    b.x0 = jitter(b.x0); b.y0 = jitter(b.y0); b.x1 = jitter(b.x1); b.y1 = jitter(b.y1);
    return b;
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || s_tvalid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic random_frames(int count);
    int r, n;
    btib_pkg::box_t b;
    for (int i = 0; i < count; ) begin
      r = $urandom_range(19);
      if (r < 14) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 19) : $urandom_range(6);
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(9))
            0: b = random_box();
            1: begin b = track_box(); b.x1 = b.x0; end
            default: b = track_box();
          endcase
          add_item(btib_pkg::CMD_ADD, b, ($urandom_range(4) == 0) ? 16'($urandom)
                                                                 : id_pool[$urandom_range(9)]);
        end
        add_item(btib_pkg::CMD_MATCH, random_box(), 16'($urandom));
        i += n + 1;
      end else if (r < 17) begin
        add_item(btib_pkg::CMD_TICK, random_box(), 16'($urandom));
        i++;
      end else begin
        add_item(btib_pkg::CMD_LOOKUP, random_box(),
                 ($urandom_range(3) == 0) ? 16'($urandom) : id_pool[$urandom_range(9)]);
        i++;
      end
    end
  endtask

  initial begin
    btib_pkg::box_t z, full, nb;
    reset_model();
    for (int k = 0; k < 10; k++) begin
      track_base[k].x0 = 12'($urandom_range(3800));
      track_base[k].y0 = 12'($urandom_range(3800));
      track_base[k].x1 = track_base[k].x0 + 12'($urandom_range(30, 290));
      track_base[k].y1 = track_base[k].y0 + 12'($urandom_range(30, 290));
      id_pool[k] = 16'($urandom);
    end
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extreme boxes and ids, a zero-area box, disjoint and
    // overlapping boxes, a pool hit by a larger box, lookups, ticks.
    z = '0;
    full = '{x0: 12'd0, y0: 12'd0, x1: 12'd4095, y1: 12'd4095};
    nb = '{x0: 12'd100, y0: 12'd100, x1: 12'd200, y1: 12'd200};
    add_item(btib_pkg::CMD_LOOKUP, z, 16'h0000);
    add_item(btib_pkg::CMD_MATCH, z, 16'h0000);
    add_item(btib_pkg::CMD_ADD, full, 16'hFFFF);
    add_item(btib_pkg::CMD_ADD, z, 16'h0000);
    add_item(btib_pkg::CMD_ADD, nb, 16'h1234);
    add_item(btib_pkg::CMD_ADD, '{x0: 12'd4095, y0: 12'd4095, x1: 12'd0, y1: 12'd0}, 16'h0001);
    add_item(btib_pkg::CMD_MATCH, z, 16'h0000);
    add_item(btib_pkg::CMD_LOOKUP, z, 16'hFFFF);
    add_item(btib_pkg::CMD_LOOKUP, z, 16'h1234);
    add_item(btib_pkg::CMD_LOOKUP, z, 16'h4321);
    add_item(btib_pkg::CMD_ADD, '{x0: 12'd95, y0: 12'd95, x1: 12'd210, y1: 12'd210}, 16'h5555);
    add_item(btib_pkg::CMD_ADD, '{x0: 12'd3000, y0: 12'd10, x1: 12'd3100, y1: 12'd90},
             16'hAAAA);
    add_item(btib_pkg::CMD_ADD, '{x0: 12'd110, y0: 12'd110, x1: 12'd150, y1: 12'd150}, 16'h7777);
    add_item(btib_pkg::CMD_MATCH, z, 16'h0000);
    add_item(btib_pkg::CMD_LOOKUP, z, 16'h5555);
    add_item(btib_pkg::CMD_TICK, full, 16'hFFFF);
    add_item(btib_pkg::CMD_TICK, z, 16'h0000);
    add_item(btib_pkg::CMD_MATCH, z, 16'h0000);
    add_item(btib_pkg::CMD_LOOKUP, z, 16'hAAAA);
    drain();

    cfg_write(btib_pkg::CFG_MUST, 8'd0);
    cfg_write(btib_pkg::CFG_MIN, 8'd0);
    cfg_write(btib_pkg::CFG_FILTER, 8'd0);
    cfg_write(btib_pkg::CFG_HOLD, 8'd1);
    random_frames(70);
    drain();

    cfg_write(btib_pkg::CFG_MUST, 8'd255);
    cfg_write(btib_pkg::CFG_MIN, 8'd255);
    cfg_write(btib_pkg::CFG_FILTER, 8'd255);
    cfg_write(btib_pkg::CFG_HOLD, 8'd255);
    random_frames(60);
    drain();

    cfg_write(btib_pkg::CFG_MUST, 8'($urandom));
    cfg_write(btib_pkg::CFG_MIN, 8'($urandom));
    cfg_write(btib_pkg::CFG_FILTER, 8'($urandom));
    cfg_write(btib_pkg::CFG_HOLD, 8'($urandom_range(1, 255)));
    random_frames(70);
    drain();

    cfg_write(btib_pkg::CFG_MUST, 8'd128);
    cfg_write(btib_pkg::CFG_MIN, 8'd64);
    cfg_write(btib_pkg::CFG_FILTER, 8'd32);
    cfg_write(btib_pkg::CFG_HOLD, 8'd3);
    random_frames(180);
    drain();

    if (fails == 0) begin
      $display("tb_box_track_id_binder_core: PASS");
    end else begin
      $display("tb_box_track_id_binder_core: FAIL");
    end
    $finish;
  end

endmodule
